FILE: design/bfa_pkg.sv
// bfa_pkg: shared widths, codes and default parameters of the bitmap frame allocator.
// Used by bitmap_frame_allocator, its checker and its testbench; depends on nothing.
package bfa_pkg;

   localparam int CNT_W  = 13;   // counts and config registers
   localparam int ADDR_W = 24;   // physical address fields
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam int FRAMES_DEF     = 4096;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'd4096;
   localparam logic [CNT_W-1:0] RESERVED_RST    = 13'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED    = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_OOM     = 2'd1,
      STAT_IGNORED = 2'd2
   } status_type;

endpackage

FILE: design/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit page frame allocator over a bitmap held in one
// synchronous RAM (one bit per frame, 1 = used). Depends on bfa_pkg.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ------------------------------
//   request   req_cmd, req_phys_addr              start high while busy low
//   result    rsp_status .. rsp_free_count        rsp_valid, one cycle, no stall
//   config    csr_index, csr_wdata                csr_we, write only
//
// Init writes one bitmap word per cycle; the alloc scan is pipelined on the single
// RAM read port, one word read and one word checked per cycle. After reset a
// clearing pass writes all MAP_WORDS words (128 by default) to all ones; busy stays
// high meanwhile, config writes still land.
// The result side cannot stall: each result is shown for exactly one cycle.
// WORD_BITS and PAGE_BYTES are powers of two, FRAMES a multiple of WORD_BITS.
module bitmap_frame_allocator #(
   parameter int FRAMES     = bfa_pkg::FRAMES_DEF,
   parameter int PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF,
   parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bfa_pkg::CMD_W-1:0]          req_cmd,
   input  logic [bfa_pkg::ADDR_W-1:0]         req_phys_addr,
   output logic                               rsp_valid,
   output logic [bfa_pkg::STAT_W-1:0]         rsp_status,
   output logic [bfa_pkg::ADDR_W-1:0]         rsp_frame_addr,
   output logic [bfa_pkg::CNT_W-1:0]          rsp_used_count,
   output logic [bfa_pkg::CNT_W-1:0]          rsp_free_count,
   input  logic                               csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfa_pkg::CNT_W-1:0]          csr_wdata
);

   localparam int CNT_W     = bfa_pkg::CNT_W;
   localparam int ADDR_W    = bfa_pkg::ADDR_W;
   localparam int MAP_WORDS = FRAMES / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int PB_LOG    = $clog2(PAGE_BYTES);
   localparam int FI_W      = AW + BW;              // frame index
   localparam int FW        = ADDR_W - PB_LOG;      // frame index taken from an address
   localparam int CW0       = (FI_W + 1 > FW) ? FI_W + 1 : FW;
   localparam int CW        = (CW0 > CNT_W) ? CW0 : CNT_W;  // compare width
   localparam int AX_W      = CW + PB_LOG + ADDR_W;
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT,
      S_SCAN,
      S_FREE
   } state_type;

   // bitmap RAM
   logic [WORD_BITS-1:0] frame_map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        mem_raddr;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_we;

   state_type            state_ff, state_in;
   logic [AW-1:0]        sweep_ptr_ff, sweep_ptr_in;
   logic [AW:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]        chk_ptr_ff, chk_ptr_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [CW-1:0]        tgt_ff, tgt_in;
   logic [CNT_W-1:0]     used_total_ff, used_total_in;
   logic [CNT_W-1:0]     frame_count_ff, reserved_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   bfa_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [CNT_W-1:0]     rsp_used_ff, rsp_used_in;
   logic [CNT_W-1:0]     rsp_free_ff, rsp_free_in;

   logic [CW-1:0]        count_w;      // frame_count clamped to FRAMES
   logic [CW-1:0]        reserve_w;
   logic [CW-1:0]        rd_base;
   logic                 rd_in_range;
   logic                 found;
   logic [BW-1:0]        found_off;
   logic [WORD_BITS-1:0] init_word;
   logic [CW-1:0]        free_frame;
   logic [AX_W-1:0]      addr_ext;
   logic [CW-1:0]        used_ext;

   assign count_w   = (CW'(frame_count_ff) > CW'(FRAMES)) ? CW'(FRAMES) : CW'(frame_count_ff);
   assign reserve_w = (CW'(reserved_ff) > CW'(FRAMES)) ? CW'(FRAMES) : CW'(reserved_ff);

   assign rd_base     = CW'({rd_ptr_ff, {BW{1'b0}}});
   assign rd_in_range = rd_base < count_w;
   assign free_frame  = CW'(req_phys_addr[ADDR_W-1:PB_LOG]);

   // lowest free bit of the checked word that lies below the frame count
   always_comb begin
      found     = 1'b0;
      found_off = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_data_ff[i] && (CW'({chk_ptr_ff, BW'(i)}) < count_w)) begin
            found     = 1'b1;
            found_off = BW'(i);
         end
      end
   end

   // word written by init: free only for reserve <= frame < count
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         init_word[i] = !((CW'({sweep_ptr_ff, BW'(i)}) >= reserve_w) &&
                          (CW'({sweep_ptr_ff, BW'(i)}) < count_w));
      end
   end

   assign addr_ext = AX_W'({chk_ptr_ff, found_off}) << PB_LOG;

   always_comb begin
      state_in      = state_ff;
      sweep_ptr_in  = sweep_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_ptr_in    = chk_ptr_ff;
      chk_vld_in    = chk_vld_ff;
      tgt_in        = tgt_ff;
      used_total_in = used_total_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = bfa_pkg::STAT_OK;
      rsp_addr_in   = '0;
      mem_raddr     = rd_ptr_ff[AW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = sweep_ptr_ff;
      mem_wdata     = '1;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we       = 1'b1;
            sweep_ptr_in = sweep_ptr_ff + 1'b1;
            if (sweep_ptr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (bfa_pkg::cmd_type'(req_cmd))
                  bfa_pkg::CMD_INIT: begin
                     sweep_ptr_in = '0;
                     state_in     = S_INIT;
                  end
                  bfa_pkg::CMD_ALLOC: begin
                     rd_ptr_in  = '0;
                     chk_vld_in = 1'b0;
                     state_in   = S_SCAN;
                  end
                  bfa_pkg::CMD_FREE: begin
                     tgt_in    = free_frame;
                     mem_raddr = free_frame[FI_W-1:BW];
                     state_in  = S_FREE;
                  end
                  bfa_pkg::CMD_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_INIT: begin
            mem_we       = 1'b1;
            mem_wdata    = init_word;
            sweep_ptr_in = sweep_ptr_ff + 1'b1;
            if (sweep_ptr_ff == LAST_WORD) begin
               // every frame below min(reserve, count) is used after init
               used_total_in = (reserve_w < count_w) ? reserve_w[CNT_W-1:0]
                                                     : count_w[CNT_W-1:0];
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            if (chk_vld_ff && found) begin
               mem_we        = 1'b1;
               mem_waddr     = chk_ptr_ff;
               mem_wdata     = rd_data_ff | (WORD_BITS'(1) << found_off);
               used_total_in = (used_total_ff == '1) ? used_total_ff : used_total_ff + 1'b1;
               rsp_addr_in   = addr_ext[ADDR_W-1:0];
               rsp_valid_in  = 1'b1;
               chk_vld_in    = 1'b0;
               state_in      = S_IDLE;
            end else if (!chk_vld_ff && !rd_in_range) begin
               rsp_status_in = bfa_pkg::STAT_OOM;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (rd_in_range) begin
               // read ahead while the previous word is checked
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_ptr_in = rd_ptr_ff[AW-1:0];
               chk_vld_in = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         S_FREE: begin
            if ((tgt_ff < count_w) && rd_data_ff[tgt_ff[BW-1:0]]) begin
               mem_we        = 1'b1;
               mem_waddr     = tgt_ff[FI_W-1:BW];
               mem_wdata     = rd_data_ff & ~(WORD_BITS'(1) << tgt_ff[BW-1:0]);
               used_total_in = (used_total_ff == '0) ? used_total_ff : used_total_ff - 1'b1;
            end else begin
               rsp_status_in = bfa_pkg::STAT_IGNORED;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign used_ext    = CW'(used_total_in);
   assign rsp_used_in = used_total_in;
   assign rsp_free_in = (count_w > used_ext) ? CNT_W'(count_w - used_ext) : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= frame_map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         sweep_ptr_ff   <= '0;
         chk_vld_ff     <= 1'b0;
         used_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= bfa_pkg::FRAME_COUNT_RST;
         reserved_ff    <= bfa_pkg::RESERVED_RST;
      end else begin
         state_ff      <= state_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         chk_vld_ff    <= chk_vld_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               bfa_pkg::CSR_FRAME_COUNT: frame_count_ff <= csr_wdata;
               bfa_pkg::CSR_RESERVED:    reserved_ff    <= csr_wdata;
               default:                  ;
            endcase
         end
      end
      rd_ptr_ff     <= rd_ptr_in;
      chk_ptr_ff    <= chk_ptr_in;
      tgt_ff        <= tgt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_addr = rsp_addr_ff;
   assign rsp_used_count = rsp_used_ff;
   assign rsp_free_count = rsp_free_ff;

   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result issued during the clearing pass");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == S_SCAN))
      else $error("scan check pending outside of the scan");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd != bfa_pkg::CMD_NOP)) |=> busy)
      else $error("multi-cycle request did not raise busy");

   a_oom_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bfa_pkg::STAT_OOM)) |-> (rsp_frame_addr == '0))
      else $error("out-of-memory result with nonzero address");

endmodule

FILE: dv/bitmap_frame_allocator_checker.sv
// bitmap_frame_allocator_checker: watches the request, result and csr ports of the
// allocator, keeps its own frame bitmap and counters, and compares every result.
// Depends on bfa_pkg; instantiated beside the block by bitmap_frame_allocator_tb.
module bitmap_frame_allocator_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [bfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bfa_pkg::ADDR_W-1:0]    req_phys_addr,
   input  logic                          rsp_valid,
   input  logic [bfa_pkg::STAT_W-1:0]    rsp_status,
   input  logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_addr,
   input  logic [bfa_pkg::CNT_W-1:0]     rsp_used_count,
   input  logic [bfa_pkg::CNT_W-1:0]     rsp_free_count,
   input  logic                          csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::CNT_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      bfa_pkg::status_type             status;
      logic [bfa_pkg::ADDR_W-1:0]      frame_addr;
      logic [bfa_pkg::CNT_W-1:0]       used_count;
      logic [bfa_pkg::CNT_W-1:0]       free_count;
   } frame_outcome_type;

   frame_outcome_type outcomes_due[$];

   bit                        frame_used [bfa_pkg::FRAMES_DEF];
   logic [bfa_pkg::CNT_W-1:0] used_total;
   logic [bfa_pkg::CNT_W-1:0] frame_count_reg;
   logic [bfa_pkg::CNT_W-1:0] reserved_reg;

   // Applies one command to the bitmap and counters, returns the result it owes.
   function automatic frame_outcome_type apply_frame_cmd(bfa_pkg::cmd_type cmd,
                                                         logic [bfa_pkg::ADDR_W-1:0] addr);
      frame_outcome_type r;
      int limit;
      int floor_idx;
      int f;
      int tally;
      bit found;
      limit = frame_count_reg;
      if (limit > bfa_pkg::FRAMES_DEF) limit = bfa_pkg::FRAMES_DEF;
      floor_idx = reserved_reg;
      if (floor_idx > bfa_pkg::FRAMES_DEF) floor_idx = bfa_pkg::FRAMES_DEF;
      r.status = bfa_pkg::STAT_OK;
      r.frame_addr = '0;
      case (cmd)
         bfa_pkg::CMD_INIT: begin
            tally = 0;
            for (f = 0; f < bfa_pkg::FRAMES_DEF; f++) begin
               frame_used[f] = !(f >= floor_idx && f < limit);
               if (f < limit && frame_used[f]) tally++;
            end
            used_total = bfa_pkg::CNT_W'(tally);
         end
         bfa_pkg::CMD_ALLOC: begin
            r.status = bfa_pkg::STAT_OOM;
            found = 0;
            for (f = 0; f < limit && !found; f++) begin
               if (!frame_used[f]) begin
                  found = 1;
                  frame_used[f] = 1;
                  if (used_total != {bfa_pkg::CNT_W{1'b1}}) used_total++;
                  r.status = bfa_pkg::STAT_OK;
                  r.frame_addr = bfa_pkg::ADDR_W'(f * bfa_pkg::PAGE_BYTES_DEF);
               end
            end
         end
         bfa_pkg::CMD_FREE: begin
            f = int'(addr / bfa_pkg::PAGE_BYTES_DEF);
            if (f < limit && frame_used[f]) begin
               frame_used[f] = 0;
               if (used_total != '0) used_total--;
            end else begin
               r.status = bfa_pkg::STAT_IGNORED;
            end
         end
         default: ;
      endcase
      r.used_count = used_total;
      r.free_count = (limit > used_total) ? bfa_pkg::CNT_W'(limit - used_total) : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      frame_outcome_type exp;
      if (reset) begin
         outcomes_due.delete();
         foreach (frame_used[i]) frame_used[i] = 1;
         used_total = '0;
         frame_count_reg = bfa_pkg::FRAME_COUNT_RST;
         reserved_reg = bfa_pkg::RESERVED_RST;
         fail_count = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (outcomes_due.size() == 0) begin
               $error("rsp_valid with no request outstanding");
               fail_count++;
            end else begin
               exp = outcomes_due.pop_front();
               if (rsp_status !== exp.status) begin
                  $error("rsp_status: expected %0d, actual %0d", exp.status, rsp_status);
                  fail_count++;
               end
               if (rsp_frame_addr !== exp.frame_addr) begin
                  $error("rsp_frame_addr: expected %h, actual %h", exp.frame_addr,
                         rsp_frame_addr);
                  fail_count++;
               end
               if (rsp_used_count !== exp.used_count) begin
                  $error("rsp_used_count: expected %0d, actual %0d", exp.used_count,
                         rsp_used_count);
                  fail_count++;
               end
               if (rsp_free_count !== exp.free_count) begin
                  $error("rsp_free_count: expected %0d, actual %0d", exp.free_count,
                         rsp_free_count);
                  fail_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            outcomes_due.push_back(apply_frame_cmd(bfa_pkg::cmd_type'(req_cmd),
                                                   req_phys_addr));
         if (csr_we === 1'b1) begin
            if (csr_index == bfa_pkg::CSR_FRAME_COUNT) frame_count_reg = csr_wdata;
            else if (csr_index == bfa_pkg::CSR_RESERVED) reserved_reg = csr_wdata;
         end
      end
      outstanding = outcomes_due.size();
   end

endmodule

FILE: dv/bitmap_frame_allocator_tb.sv
// bitmap_frame_allocator_tb: clock, reset and request/csr stimulus for the allocator,
// with a directed opening and random phases of init, alloc, free and no-op traffic.
// Depends on bfa_pkg, bitmap_frame_allocator and bitmap_frame_allocator_checker.
module bitmap_frame_allocator_tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 140;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [bfa_pkg::CMD_W-1:0]     req_cmd;
   logic [bfa_pkg::ADDR_W-1:0]    req_phys_addr;
   logic                          rsp_valid;
   logic [bfa_pkg::STAT_W-1:0]    rsp_status;
   logic [bfa_pkg::ADDR_W-1:0]    rsp_frame_addr;
   logic [bfa_pkg::CNT_W-1:0]     rsp_used_count;
   logic [bfa_pkg::CNT_W-1:0]     rsp_free_count;
   logic                          csr_we;
   logic [bfa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bfa_pkg::CNT_W-1:0]     csr_wdata;

   int fail_count;
   int outstanding;
   int cycles = 0;
   int frame_window = bfa_pkg::FRAME_COUNT_RST;

   bitmap_frame_allocator dut (
      .clock, .reset, .start, .busy, .req_cmd, .req_phys_addr,
      .rsp_valid, .rsp_status, .rsp_frame_addr, .rsp_used_count, .rsp_free_count,
      .csr_we, .csr_index, .csr_wdata
   );

   bitmap_frame_allocator_checker checker_i (
      .clock, .reset, .start, .busy, .req_cmd, .req_phys_addr,
      .rsp_valid, .rsp_status, .rsp_frame_addr, .rsp_used_count, .rsp_free_count,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .outstanding
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge once busy reads low after a
   // rising edge, start still high, so the caller either drives the next request or drops start.
   task automatic send_request(input bfa_pkg::cmd_type cmd,
                               input logic [bfa_pkg::ADDR_W-1:0] addr);
      start <= 1'b1;
      req_cmd <= cmd;
      req_phys_addr <= addr;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   // Only called while idle, start already low.
   task automatic set_config(input logic [bfa_pkg::CNT_W-1:0] count,
                             input logic [bfa_pkg::CNT_W-1:0] rsvd);
      csr_we <= 1'b1;
      csr_index <= bfa_pkg::CSR_FRAME_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_index <= bfa_pkg::CSR_RESERVED;
      csr_wdata <= rsvd;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      frame_window = (count > bfa_pkg::FRAMES_DEF) ? bfa_pkg::FRAMES_DEF : count;
   endtask

   // Mostly frames near the managed range so frees hit used frames; some noise.
   function automatic logic [bfa_pkg::ADDR_W-1:0] pick_addr();
      int f;
      if ($urandom_range(0, 99) < 15) return bfa_pkg::ADDR_W'($urandom());
      f = $urandom_range(0, frame_window + 4);
      if (f > bfa_pkg::FRAMES_DEF - 1) f = bfa_pkg::FRAMES_DEF - 1;
      return {12'(f), 12'($urandom())};
   endfunction

   function automatic logic [bfa_pkg::CNT_W-1:0] pick_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return bfa_pkg::CNT_W'($urandom_range(0, 160));
      if (pick < 85) return bfa_pkg::CNT_W'($urandom_range(0, 8191));
      return bfa_pkg::CNT_W'(bfa_pkg::FRAMES_DEF);
   endfunction

   initial begin
      logic [bfa_pkg::CNT_W-1:0] count_list [9];
      logic [bfa_pkg::CNT_W-1:0] rsvd_list [9];
      logic [bfa_pkg::CNT_W-1:0] count;
      logic [bfa_pkg::CNT_W-1:0] rsvd;
      int sent;
      int phase;
      int phase_left;
      int burst_left;
      int pick;
      bfa_pkg::cmd_type cmd;

      count_list = '{13'd4096, 13'd0, 13'd8191, 13'd1, 13'd32,
                     13'd64, 13'd4097, 13'd33, 13'd4096};
      rsvd_list  = '{13'd256, 13'd0, 13'd8191, 13'd0, 13'd31,
                     13'd64, 13'd4095, 13'd0, 13'd0};
      reset = 1'b1;
      start = 1'b0;
      req_cmd = bfa_pkg::CMD_NOP;
      req_phys_addr = '0;
      csr_we = 1'b0;
      csr_index = bfa_pkg::CSR_FRAME_COUNT;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // before any init the map reads all used while the counter is zero
      send_request(bfa_pkg::CMD_NOP, 24'hFFFFFF);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'h000ABC);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_INIT, 24'h000000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'hFFFFFF);
      send_request(bfa_pkg::CMD_FREE, 24'h100FFF);
      send_request(bfa_pkg::CMD_FREE, 24'h005000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      drain();
      set_config(13'd0, 13'd0);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'h000000);
      send_request(bfa_pkg::CMD_INIT, 24'h000000);
      drain();
      set_config(13'd8191, 13'd8191);
      send_request(bfa_pkg::CMD_INIT, 24'h000000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'hFFF000);
      drain();
      set_config(13'd2, 13'd0);
      send_request(bfa_pkg::CMD_INIT, 24'h000000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      send_request(bfa_pkg::CMD_ALLOC, 24'h000000);
      drain();
      // shrink without re-init: used count now exceeds the frame count
      set_config(13'd1, 13'd0);
      send_request(bfa_pkg::CMD_NOP, 24'h000000);
      send_request(bfa_pkg::CMD_FREE, 24'h001000);
      send_request(bfa_pkg::CMD_FREE, 24'h000000);
      drain();

      sent = 0;
      phase = 0;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 9) begin
            count = count_list[phase];
            rsvd = rsvd_list[phase];
         end else begin
            count = pick_count();
            pick = $urandom_range(0, 3);
            if (pick < 2) rsvd = bfa_pkg::CNT_W'($urandom_range(0, count));
            else if (pick == 2) rsvd = '0;
            else rsvd = bfa_pkg::CNT_W'($urandom_range(0, 8191));
         end
         phase++;
         drain();
         set_config(count, rsvd);
         phase_left = $urandom_range(60, 160);
         if ($urandom_range(0, 9) < 8) begin
            send_request(bfa_pkg::CMD_INIT, pick_addr());
            sent++;
         end
         while (phase_left > 0 && sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 9) < 7) hold_off($urandom_range(1, 12));
               else if ($urandom_range(0, 49) == 0) drain();
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 4) cmd = bfa_pkg::CMD_INIT;
            else if (pick < 50) cmd = bfa_pkg::CMD_ALLOC;
            else if (pick < 90) cmd = bfa_pkg::CMD_FREE;
            else cmd = bfa_pkg::CMD_NOP;
            send_request(cmd, pick_addr());
            sent++;
            phase_left--;
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
